### rtl/edd_pkg.sv
// Shared types, constants and arithmetic helpers for the error-diffusion dither.
// No dependencies; the top level, datapath, result queue and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

    // Frame geometry limits and fixed-point format.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int FRAC_BITS  = 8;

    localparam int PIX_BITS   = 8;
    localparam int CFG_BITS   = 11;
    localparam int ERR_BITS   = FRAC_BITS + 10;
    localparam int SUM_BITS   = ERR_BITS + 2;
    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIM_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS + 1 : ROW_BITS + 1;
    localparam int BOUND_BITS = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;

    // Diffusion weights, in sixteenths.
    localparam int WEIGHT_SHIFT = 4;
    localparam logic [2:0] W_RIGHT      = 3'd7;
    localparam logic [2:0] W_DOWN_LEFT  = 3'd3;
    localparam logic [2:0] W_DOWN       = 3'd5;
    localparam logic [2:0] W_DOWN_RIGHT = 3'd1;

    // Configuration port.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // Result queue.
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;
    typedef logic [COL_BITS-1:0]        col_t;
    typedef logic [ROW_BITS-1:0]        row_t;
    typedef logic [BOUND_BITS-1:0]      bound_t;

    localparam int ERR_MAX_I = (1 << (ERR_BITS - 1)) - 1;
    localparam sum_t SUM_ERR_MAX = SUM_BITS'(ERR_MAX_I);
    localparam sum_t SUM_ERR_MIN = -SUM_ERR_MAX - sum_t'(1);

    // Decision threshold 127.5 and full white 255.0 in fixed point.
    localparam err_t WHITE_LEVEL = ERR_BITS'(255 * (1 << (FRAC_BITS - 1)));
    localparam err_t FULL_SCALE  = ERR_BITS'(255 * (1 << FRAC_BITS));

    // Position information of the item in the compute stage.
    typedef struct packed {
        col_t col;
        logic first_row;
        logic first_col;
        logic last_col;
        logic frame_end;
    } s1_ctrl_t;

    // One write into the next-row error memory.
    typedef struct packed {
        logic en;
        col_t addr;
        err_t data;
    } mem_wr_t;

    typedef struct packed {
        logic dithered_bit;
        logic frame_end;
    } result_t;

    function automatic sum_t ext_err(input err_t e);
        return {{(SUM_BITS - ERR_BITS){e[ERR_BITS-1]}}, e};
    endfunction

    function automatic err_t sat_err(input sum_t x);
        err_t r;
        if (x > SUM_ERR_MAX) begin
            r = SUM_ERR_MAX[ERR_BITS-1:0];
        end else if (x < SUM_ERR_MIN) begin
            r = SUM_ERR_MIN[ERR_BITS-1:0];
        end else begin
            r = x[ERR_BITS-1:0];
        end
        return r;
    endfunction

    // err * weight / 16, rounded toward minus infinity. The result always fits.
    function automatic err_t share16(input err_t e, input logic [2:0] w);
        logic signed [ERR_BITS+3:0] p;
        p = $signed({{4{e[ERR_BITS-1]}}, e}) * $signed({{(ERR_BITS+1){1'b0}}, w});
        return p[ERR_BITS+3:WEIGHT_SHIFT];
    endfunction

    // Zero reads as one, values above the limit saturate to it.
    function automatic bound_t eff_bound(input logic [CFG_BITS-1:0] r, input int maxv);
        bound_t b;
        if (r == '0) begin
            b = BOUND_BITS'(1);
        end else if (int'(r) > maxv) begin
            b = BOUND_BITS'(maxv);
        end else begin
            b = BOUND_BITS'(r);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/error_diffusion_dither.sv
// Binary error-diffusion dither of a grayscale frame in raster order. Each input item is one
// 8-bit pixel and each result item is one bit (1 = white) plus a flag on the last pixel of
// the frame. The block takes one item per clock while the result queue has room; each result
// goes from the compute stage into the queue in order. The rate is set by the error memory, which is
// read once (in the accept cycle) and written once (in the compute cycle) per item, with the
// column-to-column error chain kept in registers and forwarded around the memory. A result
// queue of four items lets the input keep flowing while results wait. After reset the
// block clears every entry of the error memory and accepts no item until that pass ends;
// configuration writes are taken throughout. image_width (offset 0x0) and image_height
// (offset 0x4) should be written only while no item is in flight; a change takes effect
// on the next item, and if the column already lies at or past the new width that item ends
// the row; a row at or past the new height ends the frame.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither
    import edd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIX_BITS-1:0]      s_pixel_value,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_dithered_bit,
    output logic                     m_frame_end,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // Configuration registers.
    logic [CFG_BITS-1:0] width_reg, height_reg;
    reg_idx_t            reg_idx;
    logic                cfg_write;

    // Memory clearing pass after reset.
    logic clr_active_reg, clr_active_next;
    col_t clr_addr_reg, clr_addr_next;

    // Frame position of the next item.
    col_t col_reg, col_next;
    row_t row_reg, row_next;

    // Compute stage.
    logic                s1_valid_reg;
    s1_ctrl_t            s1_ctrl_reg, s1_ctrl_next;
    logic [PIX_BITS-1:0] s1_pixel_reg;

    logic     s_accept;
    bound_t   w_eff, h_eff;
    logic     last_col0, last_row0;
    err_t     ram_rdata;
    mem_wr_t  dp_wr;
    logic     ram_we;
    col_t     ram_waddr;
    err_t     ram_wdata;
    logic     dp_white;
    result_t  push_data, out_data;
    logic [FIFO_CNT_BITS-1:0] fifo_count;

    // Configuration port: writes complete in the access phase, reads are immediate.
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_BITS-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // An item is taken only when the result queue is sure to have room for it and for the
    // item already in the compute stage, so the compute stage itself never stalls.
    assign s_ready  = !clr_active_reg
                      && (fifo_count + FIFO_CNT_BITS'(s1_valid_reg))
                         <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
    assign s_accept = s_valid && s_ready;

    // Position decode for the item being accepted.
    always_comb begin
        w_eff     = eff_bound(width_reg, MAX_WIDTH);
        h_eff     = eff_bound(height_reg, MAX_HEIGHT);
        last_col0 = (BOUND_BITS'(col_reg) + BOUND_BITS'(1)) >= w_eff;
        last_row0 = (BOUND_BITS'(row_reg) + BOUND_BITS'(1)) >= h_eff;

        s1_ctrl_next.col       = col_reg;
        s1_ctrl_next.first_row = (row_reg == '0);
        s1_ctrl_next.first_col = (col_reg == '0);
        s1_ctrl_next.last_col  = last_col0;
        s1_ctrl_next.frame_end = last_col0 && last_row0;

        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (last_col0) begin
                col_next = '0;
                row_next = last_row0 ? '0 : row_reg + row_t'(1);
            end else begin
                col_next = col_reg + col_t'(1);
            end
        end
    end

    // The clearing pass writes zero into every entry, one per cycle.
    always_comb begin
        clr_addr_next   = clr_addr_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + col_t'(1);
            if (clr_addr_reg == col_t'(MAX_WIDTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s1_pixel_reg <= s_pixel_value;
        end
    end

    // Next-row error memory. The read for the accepted item is issued in the accept
    // cycle at its column; its data arrives in the compute cycle.
    assign ram_we    = clr_active_reg || dp_wr.en;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : dp_wr.addr;
    assign ram_wdata = clr_active_reg ? err_t'(0) : dp_wr.data;

    edd_ram #(
        .WIDTH (ERR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_err_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    edd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid_reg),
        .s1_ctrl  (s1_ctrl_reg),
        .s1_pixel (s1_pixel_reg),
        .rd_data  (ram_rdata),
        .wr       (dp_wr),
        .white    (dp_white)
    );

    // Results leave the compute stage straight into the queue.
    assign push_data.dithered_bit = dp_white;
    assign push_data.frame_end    = s1_ctrl_reg.frame_end;

    edd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (push_data),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_dithered_bit = out_data.dithered_bit;
    assign m_frame_end    = out_data.frame_end;

    // The compute stage never finds the result queue full.
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (fifo_count < FIFO_CNT_BITS'(FIFO_DEPTH)))
        else $error("result queue full while an item is in the compute stage");

    // No item writes the error memory while the clearing pass owns it.
    a_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !dp_wr.en)
        else $error("item write to the error memory during the clearing pass");

    // The last pixel of a frame returns the position to the frame origin.
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && last_col0 && last_row0) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap after the last pixel of the frame");

endmodule

`default_nettype wire

### rtl/edd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read-first: a read of the address being written returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module edd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/edd_datapath.sv
// Compute stage of the dither: threshold, error split and the memory write-back.
// Uses edd_pkg; gets the memory read data for the current column from the top level.
`timescale 1ns / 1ps
`default_nettype none

module edd_datapath
    import edd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s1_valid,
    input  s1_ctrl_t            s1_ctrl,
    input  logic [PIX_BITS-1:0] s1_pixel,
    input  err_t                rd_data,
    output mem_wr_t             wr,
    output logic                white
);

    // Row-local error terms.
    err_t right_carry_reg, right_carry_next;
    err_t diag_reg, diag_next;

    // Down share of the previous pixel; it still waits for the down-left share
    // of the pixel after it, so it has not been written to memory yet.
    err_t pend_reg, pend_next;
    col_t pend_addr_reg, pend_addr_next;
    logic pend_valid_reg, pend_valid_next;

    // Copy of the last write, for a read that was issued in the same cycle.
    mem_wr_t fwd_reg;

    err_t below_raw, below, rc_term, diag_term, val, err_q;
    err_t s_right, s_down_left, s_down, s_down_right;
    sum_t pix_fx, sum;

    always_comb begin
        // The newest copy of the entry wins.
        priority if (pend_valid_reg && pend_addr_reg == s1_ctrl.col) begin
            below_raw = pend_reg;
        end else if (fwd_reg.en && fwd_reg.addr == s1_ctrl.col) begin
            below_raw = fwd_reg.data;
        end else begin
            below_raw = rd_data;
        end

        below     = s1_ctrl.first_row ? '0 : below_raw;
        rc_term   = s1_ctrl.first_col ? '0 : right_carry_reg;
        diag_term = s1_ctrl.first_col ? '0 : diag_reg;

        pix_fx = $signed({{(SUM_BITS - PIX_BITS - FRAC_BITS){1'b0}}, s1_pixel,
                          {FRAC_BITS{1'b0}}});
        sum    = pix_fx + ext_err(rc_term) + ext_err(below);
        val    = sat_err(sum);
        white  = (val > WHITE_LEVEL);
        err_q  = white ? (val - FULL_SCALE) : val;

        s_right      = share16(err_q, W_RIGHT);
        s_down_left  = share16(err_q, W_DOWN_LEFT);
        s_down       = share16(err_q, W_DOWN);
        s_down_right = share16(err_q, W_DOWN_RIGHT);

        // The pending entry is either completed by this pixel's down-left share
        // or, on the first column, flushed as it stands.
        wr = '0;
        if (s1_valid) begin
            if (!s1_ctrl.first_col) begin
                wr.en   = 1'b1;
                wr.addr = s1_ctrl.col - col_t'(1);
                wr.data = sat_err(ext_err(pend_reg) + ext_err(s_down_left));
            end else if (pend_valid_reg) begin
                wr.en   = 1'b1;
                wr.addr = pend_addr_reg;
                wr.data = pend_reg;
            end
        end

        right_carry_next = right_carry_reg;
        diag_next        = diag_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        pend_valid_next  = pend_valid_reg;
        if (s1_valid) begin
            right_carry_next = s1_ctrl.last_col ? '0 : s_right;
            diag_next        = s1_ctrl.last_col ? '0 : s_down_right;
            pend_next        = sat_err(ext_err(diag_term) + ext_err(s_down));
            pend_addr_next   = s1_ctrl.col;
            pend_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_carry_reg <= '0;
            diag_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            fwd_reg         <= '0;
        end else begin
            right_carry_reg <= right_carry_next;
            diag_reg        <= diag_next;
            pend_valid_reg  <= pend_valid_next;
            fwd_reg         <= wr;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg      <= pend_next;
        pend_addr_reg <= pend_addr_next;
    end

endmodule

`default_nettype wire

### rtl/edd_out_fifo.sv
// Small result queue between the compute stage and the output channel.
// Uses edd_pkg for the result type and the depth.
`timescale 1ns / 1ps
`default_nettype none

module edd_out_fifo
    import edd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  result_t                  push_data,
    input  logic                     pop_ready,
    output logic                     out_valid,
    output result_t                  out_data,
    output logic [FIFO_CNT_BITS-1:0] count
);

    result_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic                     pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_error_diffusion_dither.sv
// Self-checking testbench for error_diffusion_dither: random pixel streams, random back-pressure
// and APB geometry changes, each result checked against a cycle-free dither predictor.
// Depends on rtl/edd_pkg.sv and rtl/error_diffusion_dither.sv.
`timescale 1ns / 1ps

module tb_error_diffusion_dither;
    import edd_pkg::*;

    // Stop after this many consecutive cycles in which neither channel moves an item. The
    // block clears its error memory after reset, and the longest source gap or sink stall is much
    // shorter than that pass, so this limit is several times the worst case.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1880;
    localparam int ERR_LIMIT      = (1 << (ERR_BITS - 1)) - 1;

    // Hand-picked pixels: extremes, the values on both sides of the 127.5 threshold, and
    // short frames that exercise the row and frame boundaries.
    localparam logic [PIX_BITS-1:0] DIRECTED_PIX [26] = '{
        8'd0,   8'd255, 8'd128, 8'd127,
        8'd255, 8'd0,   8'd127, 8'd128,
        8'd255, 8'd255, 8'd0,   8'd0,   8'd127, 8'd128,
        8'd128, 8'd127, 8'd255, 8'd0,   8'd200, 8'd55,
        8'd1,   8'd254, 8'd129,
        8'd126, 8'd64,  8'd192
    };

    // Kinds of picture content for a run of random pixels.
    typedef enum int {
        TEX_UNIFORM,
        TEX_THRESHOLD,
        TEX_FLAT,
        TEX_EXTREME
    } texture_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PIX_BITS-1:0]      s_pixel_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_dithered_bit;
    logic                     m_frame_end;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Pixels waiting to be driven, and the results the predictor expects, oldest first.
    logic [PIX_BITS-1:0] pixel_q [$];
    result_t             expected_q [$];

    // Predictor copy of the geometry registers and of the diffusion state.
    logic [CFG_BITS-1:0] cfg_width = CFG_BITS'(640);
    logic [CFG_BITS-1:0] cfg_height = CFG_BITS'(480);
    int                  err_below [MAX_WIDTH];
    int                  err_right = 0;
    int                  err_diag = 0;
    int                  pix_col = 0;
    int                  pix_row = 0;

    int       queued_count = 0;
    int       accepted_count = 0;
    int       result_count = 0;
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       src_gap = 0;
    int       sink_stall = 0;
    bit       src_idle_en = 1'b1;
    bit       sink_idle_en = 1'b1;
    int       flat_level = 128;

    error_diffusion_dither uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_value  (s_pixel_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dithered_bit (m_dithered_bit),
        .m_frame_end    (m_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------------------
    // Dither predictor
    // ------------------------------------------------------------------------------------

    // Every error sum is clamped to the signed ERR_BITS range.
    function automatic int clamp_err(input int x);
        int r;
        r = x;
        if (x > ERR_LIMIT) begin
            r = ERR_LIMIT;
        end else if (x < -ERR_LIMIT - 1) begin
            r = -ERR_LIMIT - 1;
        end
        return r;
    endfunction

    // err * weight / 16, rounded toward minus infinity by the arithmetic shift.
    function automatic int weighted_share(input int e, input logic [2:0] weight);
        int p;
        p = e * int'(weight);
        return p >>> WEIGHT_SHIFT;
    endfunction

    // A register value of zero means one; anything past the limit means the limit.
    function automatic int eff_dim(input logic [CFG_BITS-1:0] r, input int maxv);
        int d;
        d = int'(r);
        if (d == 0) begin
            d = 1;
        end else if (d > maxv) begin
            d = maxv;
        end
        return d;
    endfunction

    // Dither one accepted pixel and queue the result it must produce.
    function automatic void dither_predict(input logic [PIX_BITS-1:0] px);
        int      w;
        int      h;
        int      c;
        int      below;
        int      level;
        int      err;
        logic    last_col;
        logic    last_row;
        logic    white;
        result_t res;
        w = eff_dim(cfg_width, MAX_WIDTH);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        c = (pix_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : pix_col;
        last_col = (c + 1 >= w);
        last_row = (pix_row + 1 >= h);

        // The error store is ignored on the first row of every frame, and the rightward
        // carry is ignored at the start of every row.
        below = (pix_row == 0) ? 0 : err_below[c];
        level = clamp_err((int'(px) << FRAC_BITS) + ((c == 0) ? 0 : err_right) + below);
        white = (level > 255 * (1 << (FRAC_BITS - 1)));
        err = white ? level - 255 * (1 << FRAC_BITS) : level;

        // The down share joins the down-right share left by the previous pixel; the
        // down-left share is added into the entry the previous pixel just wrote.
        err_below[c] = clamp_err(((c == 0) ? 0 : err_diag) + weighted_share(err, W_DOWN));
        if (c > 0) begin
            err_below[c-1] = clamp_err(err_below[c-1] + weighted_share(err, W_DOWN_LEFT));
        end
        err_right = last_col ? 0 : clamp_err(weighted_share(err, W_RIGHT));
        err_diag = last_col ? 0 : clamp_err(weighted_share(err, W_DOWN_RIGHT));

        res.dithered_bit = white;
        res.frame_end = last_col && last_row;
        expected_q.push_back(res);

        if (last_col) begin
            pix_col = 0;
            pix_row = last_row ? 0 : pix_row + 1;
        end else begin
            pix_col = c + 1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // ------------------------------------------------------------------------------------
    // Random idling
    // ------------------------------------------------------------------------------------

    // Mostly no gap or a short one, now and then a long one; none at all when idling is off.
    function automatic int pick_gap(input bit enabled);
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = 0;
        if (!enabled || r < 55) begin
            g = 0;
        end else if (r < 85) begin
            g = $urandom_range(1, 3);
        end else if (r < 97) begin
            g = $urandom_range(4, 12);
        end else begin
            g = $urandom_range(20, 80);
        end
        return g;
    endfunction

    // The source presents the next queued pixel once any gap has run out. A pixel that is
    // not yet accepted stays on the port unchanged, and a follow-on pixel replaces an
    // accepted one in the same assignment so valid is never dropped and raised in one step.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            s_valid <= 1'b1;
        end else if (src_gap > 0) begin
            src_gap = src_gap - 1;
            s_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
            s_valid <= 1'b1;
            s_pixel_value <= pixel_q.pop_front();
            src_gap = pick_gap(src_idle_en);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // The sink takes results with random stalls of its own.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_stall = pick_gap(sink_idle_en);
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor: predicts on every accepted pixel, checks every accepted result, and ends the
    // run if both channels stay quiet for too long.
    // ------------------------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                dither_predict(s_pixel_value);
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item expected",
                                              result_count));
                end else begin
                    want = expected_q.pop_front();
                    if (m_dithered_bit !== want.dithered_bit) begin
                        report_mismatch($sformatf("result %0d dithered_bit %b, expected %b",
                                                  result_count, m_dithered_bit,
                                                  want.dithered_bit));
                    end
                    if (m_frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                                  result_count, m_frame_end, want.frame_end));
                    end
                end
                result_count++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("error_diffusion_dither test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------------------

    function automatic logic [APB_ADDR_BITS-1:0] reg_addr(input reg_idx_t idx);
        return APB_ADDR_BITS'({idx, 2'b00});
    endfunction

    // One APB write: setup cycle, access cycle, then the bus returns to idle. Sometimes the
    // unused upper data bits carry junk, which the register must drop.
    task automatic apb_write(input reg_idx_t idx, input logic [CFG_BITS-1:0] val);
        logic [APB_DATA_BITS-1:0] word;
        word = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            word = '0;
        end
        word[CFG_BITS-1:0] = val;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= reg_addr(idx);
        pwdata <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = val;
        end else begin
            cfg_height = val;
        end
    endtask

    // One APB read, checked against the value last written (or the reset value).
    task automatic apb_read_check(input reg_idx_t idx);
        logic [CFG_BITS-1:0] want;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= reg_addr(idx);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        want = (idx == REG_IMAGE_WIDTH) ? cfg_width : cfg_height;
        if (prdata[CFG_BITS-1:0] !== want) begin
            report_mismatch($sformatf("register %s read %0d, expected %0d", idx.name(),
                                      prdata[CFG_BITS-1:0], want));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h);
        apb_write(REG_IMAGE_WIDTH, CFG_BITS'(w));
        apb_write(REG_IMAGE_HEIGHT, CFG_BITS'(h));
        apb_read_check(REG_IMAGE_WIDTH);
        apb_read_check(REG_IMAGE_HEIGHT);
    endtask

    // Block until every queued pixel has been accepted and every result has come back.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic queue_directed(input int first, input int count);
        for (int i = first; i < first + count; i++) begin
            pixel_q.push_back(DIRECTED_PIX[i]);
        end
        queued_count += count;
    endtask

    function automatic logic [PIX_BITS-1:0] next_pixel(input texture_t tex);
        int v;
        case (tex)
            TEX_UNIFORM: begin
                v = $urandom_range(0, 255);
            end
            TEX_THRESHOLD: begin
                v = $urandom_range(118, 137);
            end
            TEX_FLAT: begin
                v = flat_level + $urandom_range(0, 6) - 3;
                v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 255;
                    2: v = 1;
                    default: v = 254;
                endcase
            end
        endcase
        return PIX_BITS'(v);
    endfunction

    task automatic queue_random(input int count);
        texture_t tex;
        tex = texture_t'($urandom_range(0, 3));
        flat_level = $urandom_range(0, 255);
        for (int i = 0; i < count; i++) begin
            // A pure texture with now and then a fully random pixel thrown in.
            pixel_q.push_back(($urandom_range(0, 9) == 0) ? next_pixel(TEX_UNIFORM)
                                                         : next_pixel(tex));
        end
        queued_count += count;
    endtask

    // Frame sizes are mostly small so that many frames pass; now and then zero, a size past
    // the limit, or the limit itself.
    function automatic int pick_dim();
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            d = $urandom_range(1, 12);
        end else if (r < 85) begin
            d = $urandom_range(13, 64);
        end else if (r < 93) begin
            d = $urandom_range(65, 2047);
        end else if (r < 96) begin
            d = 0;
        end else begin
            d = ($urandom_range(0, 1) == 1) ? 1024 : 2047;
        end
        return d;
    endfunction

    initial begin
        int random_count;
        int n;
        int action;

        random_count = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            err_below[i] = 0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. First a few pixels under the reset geometry, with its values
        // read back, then one-pixel frames from zero-sized registers, then a small frame.
        apb_read_check(REG_IMAGE_WIDTH);
        apb_read_check(REG_IMAGE_HEIGHT);
        queue_directed(0, 4);
        wait_drained();
        set_geometry(0, 0);
        queue_directed(4, 4);
        wait_drained();
        set_geometry(4, 3);
        queue_directed(8, 12);
        wait_drained();

        // A width change in mid row: three pixels into a five-wide row the width drops to
        // two, so the next pixel must close the row at once.
        set_geometry(5, 2);
        queue_directed(20, 3);
        wait_drained();
        apb_write(REG_IMAGE_WIDTH, CFG_BITS'(2));
        queue_directed(23, 3);
        wait_drained();

        // Widest rows: an over-range width saturates to the limit, then the exact limit,
        // then a narrow width while the column is far past it.
        set_geometry(2047, 2);
        queue_random(400);
        wait_drained();
        apb_write(REG_IMAGE_WIDTH, CFG_BITS'(1024));
        queue_random(100);
        wait_drained();
        apb_write(REG_IMAGE_WIDTH, CFG_BITS'(7));
        queue_random(30);
        wait_drained();

        // Tallest frames, one pixel wide, with the same sequence of height changes.
        sink_idle_en = 1'b0;
        set_geometry(1, 2047);
        queue_random(300);
        wait_drained();
        apb_write(REG_IMAGE_HEIGHT, CFG_BITS'(1024));
        queue_random(20);
        wait_drained();
        apb_write(REG_IMAGE_HEIGHT, CFG_BITS'(3));
        queue_random(20);
        wait_drained();
        sink_idle_en = 1'b1;
        random_count = 870;

        // Random phases. Each ends with the source held back until every result is in, so
        // the geometry can be changed safely; some phases keep it and simply continue the
        // frame after the pause.
        while (random_count < RANDOM_ITEMS) begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            action = $urandom_range(0, 99);
            if (action < 15) begin
                // Keep the geometry and carry on mid frame.
            end else if (action < 25) begin
                apb_write(REG_IMAGE_WIDTH, CFG_BITS'(pick_dim()));
            end else if (action < 30) begin
                apb_write(REG_IMAGE_HEIGHT, CFG_BITS'(pick_dim()));
            end else begin
                set_geometry(pick_dim(), pick_dim());
            end
            n = $urandom_range(8, 100);
            queue_random(n);
            random_count += n;
            wait_drained();
        end

        // Everything has come back; let the clock run on before the verdict so that any stray
        // result shows.
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("error_diffusion_dither test passed");
        end else begin
            $display("error_diffusion_dither test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/edd_pkg.sv
rtl/edd_ram.sv
rtl/edd_datapath.sv
rtl/edd_out_fifo.sv
rtl/error_diffusion_dither.sv
tb/sv/tb_error_diffusion_dither.sv
